// File: hdl/ber_pkg.sv
// Shared types, constants and helpers for the bit error rate meter.
`timescale 1ns / 1ps

package ber_pkg;

  // Default sizes of the counters and the ratio
  localparam int unsigned COUNT_WIDTH_DEF   = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Fixed field widths of the stream ports
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned ERR_W      = 32;
  localparam int unsigned TOT_W      = 32;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned OUT_DATA_W = 88;

  // Bits added to the total count for every byte pair
  localparam int unsigned BITS_PER_BYTE = 8;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    BerIdle,
    BerDivide,
    BerHold
  } ber_state_e;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } ber_div_status_t;

  // Number of ones in one byte
  function automatic logic [3:0] ones_in_byte(input logic [BYTE_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: hdl/ber_divider.sv
// Restoring divider that forms floor(num * 2^FRACTION_BITS / den), one bit per cycle.
`timescale 1ns / 1ps

module ber_divider #(
  parameter int unsigned COUNT_WIDTH   = ber_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = ber_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [COUNT_WIDTH-1:0]     num_i,   // numerator, never above den_i
  input  logic [COUNT_WIDTH-1:0]     den_i,
  output ber_pkg::ber_div_status_t   status_o,
  output logic [FRACTION_BITS:0]     quot_o
);

  localparam int unsigned STEP_W = $clog2(FRACTION_BITS + 1);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [COUNT_WIDTH-1:0]   rem_q, rem_d;
  logic [COUNT_WIDTH-1:0]   den_q, den_d;
  logic [FRACTION_BITS:0]   quot_q, quot_d;

  logic [COUNT_WIDTH:0]     trial;
  logic [COUNT_WIDTH:0]     diff;
  logic                     fits;
  logic                     last_step;

  // One compare-and-subtract per cycle; the first step yields the integer bit
  always_comb begin
    trial     = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff      = trial - {1'b0, den_q};
    fits      = (trial >= {1'b0, den_q});
    last_step = (step_q == STEP_W'(FRACTION_BITS));
  end

  // Sequencing of the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      quot_d = {quot_q[FRACTION_BITS-1:0], fits};
      step_d = step_q + STEP_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

// File: hdl/bit_error_rate_meter.sv
// Top level of the bit error rate meter: counters, sequencer and result register.
// Byte pairs without the last mark are taken one per cycle and counted at once.
// A pair with the last mark starts the divider: the block is not ready while the
// divider forms the quotient, one step per quotient bit, nor while a finished result
// waits for the output to free; the result register is loaded once the divider is done.
// Reset (rst_ni low, asynchronous) clears both counts and drops all valids.
`timescale 1ns / 1ps

module bit_error_rate_meter #(
  parameter int unsigned COUNT_WIDTH   = ber_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = ber_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] received_byte, [15:8] reference_byte
  input  logic [ber_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tlast,   // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] error_bits, [63:32] total_bits, [80:64] error_ratio, [87:81] zero
  output logic [ber_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  ber_pkg::ber_state_e       state_q, state_d;
  ber_pkg::ber_div_status_t  div_status;

  logic [COUNT_WIDTH-1:0]    err_q, err_d;
  logic [COUNT_WIDTH-1:0]    tot_q, tot_d;
  logic [COUNT_WIDTH:0]      err_sum;
  logic [COUNT_WIDTH:0]      tot_sum;
  logic [COUNT_WIDTH-1:0]    err_next;
  logic [COUNT_WIDTH-1:0]    tot_next;
  logic [COUNT_WIDTH-1:0]    snap_err_q;
  logic [COUNT_WIDTH-1:0]    snap_tot_q;
  logic [FRACTION_BITS:0]    quot;

  logic                      s_ready;
  logic                      s_accept;
  logic                      div_start;
  logic                      out_free;
  logic                      out_load;
  logic                      out_valid_q;
  logic [ber_pkg::ERR_W-1:0]   out_err_q;
  logic [ber_pkg::TOT_W-1:0]   out_tot_q;
  logic [ber_pkg::RATIO_W-1:0] out_ratio_q;

  assign s_accept  = s_axis_tvalid && s_ready;
  assign div_start = s_accept && s_axis_tlast;
  assign out_free  = !out_valid_q || m_axis_tready;

  // Saturating count update for the incoming pair
  always_comb begin
    err_sum  = {1'b0, err_q} + (COUNT_WIDTH + 1)'(ber_pkg::ones_in_byte(
                 s_axis_tdata[ber_pkg::BYTE_W-1:0] ^
                 s_axis_tdata[ber_pkg::IN_DATA_W-1:ber_pkg::BYTE_W]));
    tot_sum  = {1'b0, tot_q} + (COUNT_WIDTH + 1)'(ber_pkg::BITS_PER_BYTE);
    err_next = err_sum[COUNT_WIDTH] ? '1 : err_sum[COUNT_WIDTH-1:0];
    tot_next = tot_sum[COUNT_WIDTH] ? '1 : tot_sum[COUNT_WIDTH-1:0];
  end

  // Counters clear once a run closes
  always_comb begin
    err_d = err_q;
    tot_d = tot_q;
    if (s_accept) begin
      err_d = s_axis_tlast ? '0 : err_next;
      tot_d = s_axis_tlast ? '0 : tot_next;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ber_pkg::BerIdle: begin
        if (div_start) state_d = ber_pkg::BerDivide;
      end
      ber_pkg::BerDivide: begin
        if (div_status.done) state_d = out_free ? ber_pkg::BerIdle : ber_pkg::BerHold;
      end
      ber_pkg::BerHold: begin
        if (out_free) state_d = ber_pkg::BerIdle;
      end
      default: state_d = ber_pkg::BerIdle;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_ready  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ber_pkg::BerIdle:   s_ready  = 1'b1;
      ber_pkg::BerDivide: out_load = div_status.done && out_free;
      ber_pkg::BerHold:   out_load = out_free;
      default: begin
        s_ready  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ber_pkg::BerIdle;
      err_q       <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      tot_q   <= tot_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Run totals held for the result while the divider works
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      snap_err_q <= err_next;
      snap_tot_q <= tot_next;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_err_q   <= ber_pkg::ERR_W'(snap_err_q);
      out_tot_q   <= ber_pkg::TOT_W'(snap_tot_q);
      out_ratio_q <= ber_pkg::RATIO_W'(quot);
    end
  end

  ber_divider #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (err_next),
    .den_i   (tot_next),
    .status_o(div_status),
    .quot_o  (quot)
  );

  assign s_axis_tready = s_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (ber_pkg::OUT_DATA_W - ber_pkg::ERR_W - ber_pkg::TOT_W - ber_pkg::RATIO_W)'(0),
    out_ratio_q, out_tot_q, out_err_q
  };

endmodule

// File: hdl/ber_checker.sv
// Port-level checks of the bit error rate meter, bound to the top level.
`timescale 1ns / 1ps

module ber_checker #(
  parameter int unsigned COUNT_WIDTH = ber_pkg::COUNT_WIDTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ber_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Closing a run occupies the divider, so no request is taken next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s_axis_tlast |=> !s_axis_tready)
    else $error("request taken while the ratio is being formed");

  // A fresh result needs the divider to run first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("result appeared before the division could finish");

  // Error count never passes the bit count (holds while counts fit the fields)
  if (COUNT_WIDTH <= ber_pkg::ERR_W) begin : g_err_le_tot
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[31:0] <= m_axis_tdata[63:32]))
      else $error("error bits exceed total bits");
  end

endmodule

bind bit_error_rate_meter ber_checker #(
  .COUNT_WIDTH(COUNT_WIDTH)
) u_ber_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// File: test/bit_error_rate_meter_tb.sv
// Self-checking stream testbench for the bit error rate meter.
`timescale 1ns / 1ps

module bit_error_rate_meter_tb;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned HOLD_OFF       = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_PAIRS   = 1250;

  // One request on the input stream
  typedef struct packed {
    logic [ber_pkg::BYTE_W-1:0] rx_byte;
    logic [ber_pkg::BYTE_W-1:0] ref_byte;
    logic                       last;
  } pair_t;

  // One expected measurement
  typedef struct packed {
    logic [ber_pkg::ERR_W-1:0]   err_bits;
    logic [ber_pkg::TOT_W-1:0]   tot_bits;
    logic [ber_pkg::RATIO_W-1:0] ratio;
  } ber_result_t;

  // Error mask patterns for generated runs
  typedef enum int {
    MaskNone,
    MaskSingle,
    MaskSparse,
    MaskRandom,
    MaskFull
  } mask_kind_e;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [ber_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                           s_axis_tlast  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [ber_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  pair_t       pair_queue[$];
  ber_result_t ratio_expect[$];

  // Running counts of the predictor
  logic [ber_pkg::ERR_W-1:0] err_acc = '0;
  logic [ber_pkg::TOT_W-1:0] tot_acc = '0;

  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned pairs_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned run_len      = 0;
  int unsigned longest_run  = 0;
  int unsigned full_runs    = 0;
  int unsigned clean_runs   = 0;
  bit          hold_done    = 1'b0;

  bit_error_rate_meter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 100);
  endfunction

  // Add to a count, sticking at all ones
  function automatic logic [ber_pkg::ERR_W-1:0] sat_sum(
      input logic [ber_pkg::ERR_W-1:0] a,
      input logic [ber_pkg::ERR_W-1:0] b);
    logic [ber_pkg::ERR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ber_pkg::ERR_W] ? '1 : s[ber_pkg::ERR_W-1:0];
  endfunction

  // Predictor: count one pair, close the measurement on the last mark
  task automatic account_pair(input logic [ber_pkg::BYTE_W-1:0] rx,
                              input logic [ber_pkg::BYTE_W-1:0] rb,
                              input logic last);
    ber_result_t res;
    logic [63:0] quot;
    err_acc = sat_sum(err_acc, ber_pkg::ERR_W'($countones(rx ^ rb)));
    tot_acc = sat_sum(tot_acc, ber_pkg::ERR_W'(ber_pkg::BITS_PER_BYTE));
    run_len++;
    if (last) begin
      quot = (tot_acc == '0) ? 64'd0 :
             ({32'd0, err_acc} << ber_pkg::FRACTION_BITS_DEF) / {32'd0, tot_acc};
      res.err_bits = err_acc;
      res.tot_bits = tot_acc;
      res.ratio    = quot[ber_pkg::RATIO_W-1:0];
      ratio_expect.push_back(res);
      if (run_len > longest_run) longest_run = run_len;
      if (err_acc == tot_acc) full_runs++;
      if (err_acc == '0) clean_runs++;
      run_len = 0;
      err_acc = '0;
      tot_acc = '0;
    end
  endtask

  // Compare one measurement from the block with the oldest expectation
  task automatic check_result(input logic [ber_pkg::OUT_DATA_W-1:0] data);
    ber_result_t got;
    ber_result_t want;
    got.err_bits = data[31:0];
    got.tot_bits = data[63:32];
    got.ratio    = data[80:64];
    results_seen++;
    if (ratio_expect.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result with nothing expected: err %0d tot %0d ratio %0d",
                 $realtime, got.err_bits, got.tot_bits, got.ratio);
    end else begin
      want = ratio_expect.pop_front();
      if (got != want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display({"%0t: mismatch: expected err %0d tot %0d ratio %0d,",
                    " got err %0d tot %0d ratio %0d"},
                   $realtime, want.err_bits, want.tot_bits, want.ratio,
                   got.err_bits, got.tot_bits, got.ratio);
      end
    end
  endtask

  task automatic queue_pair(input logic [ber_pkg::BYTE_W-1:0] rx,
                            input logic [ber_pkg::BYTE_W-1:0] rb,
                            input logic last);
    pair_t p;
    p.rx_byte  = rx;
    p.ref_byte = rb;
    p.last     = last;
    pair_queue.push_back(p);
  endtask

  // One run of random bytes with a chosen error density
  task automatic queue_run(input int unsigned len);
    mask_kind_e  kind;
    logic [7:0]  rx;
    logic [7:0]  mask;
    kind = mask_kind_e'($urandom_range(MaskNone, MaskFull));
    for (int unsigned i = 0; i < len; i++) begin
      rx = 8'($urandom);
      case (kind)
        MaskNone:   mask = 8'h00;
        MaskSingle: mask = ($urandom_range(0, 3) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
        MaskSparse: mask = 8'($urandom & $urandom & $urandom);
        MaskRandom: mask = 8'($urandom);
        default:    mask = 8'hFF;
      endcase
      queue_pair(rx, rx ^ mask, i == len - 1);
    end
  endtask

  // Input side: hold each request until taken, random gaps between requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_left      = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        account_pair(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
        pairs_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // keep offering the same request
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pair_queue.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pair_queue[0].ref_byte, pair_queue[0].rx_byte};
        s_axis_tlast  <= pair_queue[0].last;
        void'(pair_queue.pop_front());
        // every third block of 100 pairs goes back to back
        if ((pairs_sent % 300) < 100 || $urandom_range(0, 1) == 0)
          gap_left = 0;
        else
          gap_left = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: check results, random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (!hold_done && results_seen == 12) begin
        hold_done  = 1'b1;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ((results_seen % 20) >= 6 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, ratio_expect.size());
        $display("bit_error_rate_meter_tb: errors");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned queued;
    int unsigned r;
    int unsigned len;

    // single pairs: no error, every bit wrong both ways, equal extremes
    queue_pair(8'h00, 8'h00, 1'b1);
    queue_pair(8'hFF, 8'h00, 1'b1);
    queue_pair(8'h00, 8'hFF, 1'b1);
    queue_pair(8'hA5, 8'hA5, 1'b1);
    queue_pair(8'hFF, 8'hFF, 1'b1);
    // short run with lowest bit, highest bit, then every bit wrong between alternating patterns
    queue_pair(8'h01, 8'h00, 1'b0);
    queue_pair(8'h80, 8'h00, 1'b0);
    queue_pair(8'h55, 8'hAA, 1'b1);
    // one wrong bit in three bytes
    queue_pair(8'h10, 8'h00, 1'b0);
    queue_pair(8'h00, 8'h00, 1'b0);
    queue_pair(8'h00, 8'h00, 1'b1);
    // one wrong bit in seven bytes, a ratio with a repeating fraction
    for (int i = 0; i < 7; i++) queue_pair(8'h3C, (i == 3) ? 8'h34 : 8'h3C, i == 6);

    // random runs, mostly short, some long
    queued = 0;
    while (queued < RANDOM_PAIRS) begin
      r = $urandom_range(0, 99);
      if (r < 50) len = $urandom_range(1, 8);
      else if (r < 85) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      queue_run(len);
      queued += len;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pair_queue.size() != 0 || s_axis_tvalid || ratio_expect.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d byte pairs in %0d runs checked, longest run %0d pairs",
             pairs_sent, results_seen, longest_run);
    $display("%0d runs with every bit wrong, %0d runs with no error, %0d mismatches",
             full_runs, clean_runs, fail_count);
    if (fail_count == 0 && ratio_expect.size() == 0)
      $display("bit_error_rate_meter_tb: clean");
    else
      $display("bit_error_rate_meter_tb: errors");
    $finish;
  end

endmodule
